// ===== hdl/bounded_deque_with_delete_unit_macros.svh =====
// Assertion macros used by the deque unit.
`ifndef BOUNDED_DEQUE_WITH_DELETE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_DELETE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that prop holds at every clock edge out of reset.
`define BDQ_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that cond never holds out of reset.
`define BDQ_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define BDQ_ASSERT(lbl, clk, rstn, prop, msg)
`define BDQ_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== hdl/bdq_pkg.sv =====
`timescale 1ns / 1ps
package bdq_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int OP_W    = 3;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_DELETE     = 3'd4,
		OP_FIND       = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Command broadcast to every cell for one beat.
	typedef struct packed {
		logic                    push_front;
		logic                    push_back;
		logic                    pop_front;
		logic                    del;
		logic signed [VAL_W-1:0] key;
	} bdq_cmd_t;

endpackage

// ===== hdl/bdq_req_if.sv =====
`timescale 1ns / 1ps
interface bdq_req_if
	import bdq_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

// ===== hdl/bdq_rsp_if.sv =====
`timescale 1ns / 1ps
interface bdq_rsp_if
	import bdq_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] data;
	logic [POS_W-1:0]        position;
	logic [COUNT_W-1:0]      count;

	modport source (output valid, output status, output data, output position, output count,
		input ready);
	modport sink (input valid, input status, input data, input position, input count,
		output ready);
endinterface

// ===== hdl/bdq_cell.sv =====
`timescale 1ns / 1ps
module bdq_cell
	import bdq_pkg::*;
(
	input  logic                    clk,
	input  bdq_cmd_t                cmd,
	input  logic                    occ,
	input  logic                    prev_occ,
	input  logic signed [VAL_W-1:0] left_val,
	input  logic signed [VAL_W-1:0] right_val,
	input  logic                    hit_in,
	output logic signed [VAL_W-1:0] val,
	output logic                    hit_out,
	output logic                    first
);

	logic signed [VAL_W-1:0] val_q;
	logic                    match;

	assign match   = occ && (val_q == cmd.key);
	assign hit_out = hit_in | match;
	assign first   = match & ~hit_in;
	assign val     = val_q;

	always_ff @(posedge clk) begin
		if (cmd.pop_front) begin
			val_q <= right_val;
		end else if (cmd.push_front) begin
			val_q <= left_val;
		end else if (cmd.push_back && !occ && prev_occ) begin
			val_q <= cmd.key;
		end else if (cmd.del && occ && hit_out) begin
			// close the gap: everything from the match on moves one step forward
			val_q <= right_val;
		end
	end

endmodule

// ===== hdl/bounded_deque_with_delete_unit.sv =====
`timescale 1ns / 1ps
// Bounded double-ended queue of up to DEPTH signed 32-bit values, held in a
// row of cells with the front in cell 0. Each request beat carries one
// operation (push front/back, pop front/back, delete first match, find first
// match) and gives exactly one response beat with status, popped data, match
// position and the entry count after the operation. Every cell compares its
// value with the key at once and a hit chain runs down the row to pick the
// first match; shifts for push front, pop front and delete are done on the
// same clock edge as each cell loads from its neighbor. A new beat is accepted
// every cycle while the response register is empty or being drained in that
// same cycle. Pushes into a full queue are refused with status full; pops
// from an empty queue and unmatched deletes or finds report status empty.
// Unused op codes leave the queue alone and report done.
module bounded_deque_with_delete_unit
	import bdq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);

`include "bounded_deque_with_delete_unit_macros.svh"

	logic [CNT_W-1:0]        count_q;
	logic                    out_valid_q;
	logic [STAT_W-1:0]       status_q;
	logic signed [VAL_W-1:0] data_q;
	logic [POS_W-1:0]        position_q;

	logic                    fire;
	op_t                     op;
	logic                    full;
	logic                    empty;
	bdq_cmd_t                cmd;

	logic [DEPTH-1:0]        occ;
	logic [DEPTH:0]          hit;
	logic [DEPTH-1:0]        first;
	logic signed [VAL_W-1:0] cell_val [DEPTH];
	logic signed [VAL_W-1:0] back_val;
	logic [IDX_W-1:0]        match_idx;

	logic [CNT_W-1:0]        count_d;
	status_t                 status_d;
	logic signed [VAL_W-1:0] data_d;
	logic [POS_W-1:0]        position_d;

	// Take a new beat whenever the response register is free or draining.
	assign req.ready = !out_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign op        = op_t'(req.op);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	// Broadcast command, gated so that refused operations leave cells alone.
	always_comb begin
		cmd            = '0;
		cmd.key        = req.value;
		cmd.push_front = fire && (op == OP_PUSH_FRONT) && !full;
		cmd.push_back  = fire && (op == OP_PUSH_BACK) && !full;
		cmd.pop_front  = fire && (op == OP_POP_FRONT) && !empty;
		cmd.del        = fire && (op == OP_DELETE);
	end

	assign hit[0] = 1'b0;

	// Row of cells; the key enters at the front for push front, the last cell
	// feeds itself back on shifts toward the front.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count_q);

		bdq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occ       (occ[i]),
			.prev_occ  ((i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i - 1]),
			.left_val  ((i == 0) ? cmd.key : cell_val[(i == 0) ? 0 : i - 1]),
			.right_val (cell_val[(i == DEPTH - 1) ? i : i + 1]),
			.hit_in    (hit[i]),
			.val       (cell_val[i]),
			.hit_out   (hit[i+1]),
			.first     (first[i])
		);
	end

	// Gather the back entry and the first-match index; at most one cell drives each.
	always_comb begin
		back_val  = '0;
		match_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (occ[i] && ((i == DEPTH - 1) || !occ[(i == DEPTH - 1) ? i : i + 1])) begin
				back_val = back_val | cell_val[i];
			end
			if (first[i]) begin
				match_idx = match_idx | IDX_W'(i);
			end
		end
	end

	// Response and next count.
	always_comb begin
		count_d    = count_q;
		status_d   = ST_DONE;
		data_d     = '0;
		position_d = '0;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					data_d  = cell_val[0];
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					data_d  = back_val;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (!hit[DEPTH]) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_FIND: begin
				if (!hit[DEPTH]) begin
					status_d = ST_EMPTY;
				end else begin
					position_d = POS_W'(match_idx);
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the count and the response valid flag; load the new count on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				// drop the response once it has been taken
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q   <= status_d;
			data_q     <= data_d;
			position_q <= position_d;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = status_q;
	assign rsp.data     = data_q;
	assign rsp.position = position_q;
	assign rsp.count    = COUNT_W'(count_q);

	`BDQ_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(DEPTH), "entry count above depth")
	`BDQ_ASSERT(a_first_onehot, clk, arst_n, $onehot0(first), "more than one first match")
	`BDQ_ASSERT(a_push_count, clk, arst_n, (fire && (op == OP_PUSH_BACK) && !full) |=> (count_q == $past(count_q) + CNT_W'(1)), "push did not advance count")
	`BDQ_ASSERT(a_full_status, clk, arst_n, (out_valid_q && (status_q == ST_FULL)) |-> (count_q == CNT_W'(DEPTH)), "full status with room left")

endmodule
